### rtl/vras_pkg.sv
// shared types, constants and helpers for the versioned range add and sum block
package vras_pkg;

   localparam int MAX_ELEMENTS  = 64;
   localparam int IDX_W         = $clog2(MAX_ELEMENTS);
   localparam int MAX_VERSIONS  = 256;
   localparam int VER_W         = $clog2(MAX_VERSIONS) + 1;
   localparam int LOG_W         = $clog2(MAX_VERSIONS);
   localparam int MAX_SNAPSHOTS = 17;
   localparam int SLOT_W        = $clog2(MAX_SNAPSHOTS);
   localparam int SNAP_DEPTH    = MAX_SNAPSHOTS * MAX_ELEMENTS;
   localparam int DATA_W        = 64;
   localparam int WIDE_W        = 72;
   localparam int SIZE_W        = 7;
   localparam int IVL_W         = 9;
   localparam int IVL_MIN       = 16;
   localparam int IVL_MAX       = 256;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_ADD  = 2'd1;
   localparam logic [1:0] ACT_SUM  = 2'd2;

   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_RANGE    = 3'd1;
   localparam logic [2:0] ERR_VERSION  = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW = 3'd3;
   localparam logic [2:0] ERR_FULL     = 3'd4;

   localparam logic REG_SIZE     = 1'b0;
   localparam logic REG_INTERVAL = 1'b1;

   typedef struct packed {
      logic fits;
      logic neg;
      logic zero;
   } alu_flags_type;

   function automatic logic [WIDE_W-1:0] sext_wide(input logic [DATA_W-1:0] v);
      sext_wide = {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

endpackage

### rtl/vras_alu.sv
// shared wide adder and subtractor with signed range flags
module vras_alu (
   input  logic [vras_pkg::WIDE_W-1:0] op_a,
   input  logic [vras_pkg::WIDE_W-1:0] op_b,
   input  logic                        subtract,
   output logic [vras_pkg::WIDE_W-1:0] result,
   output vras_pkg::alu_flags_type     flags
);
   import vras_pkg::*;

   logic [WIDE_W-1:0] b_eff;

   assign b_eff  = subtract ? ~op_b : op_b;
   assign result = op_a + b_eff + {{(WIDE_W-1){1'b0}}, subtract};

   assign flags.fits = (result[WIDE_W-1:DATA_W-1] == '0) || (result[WIDE_W-1:DATA_W-1] == '1);
   assign flags.neg  = result[WIDE_W-1];
   assign flags.zero = (result == '0);
endmodule

### rtl/versioned_range_add_sum_tree.sv
// top level of the versioned range add and range sum block
//
// an item is taken on start while busy is low unless a config write comes with it; one result
// follows, shown for a single cycle with rsp_strobe, and the receiver cannot hold it off
// load: writes one element after an overflow sweep over all elements in use,
//   then copies the live array to checkpoint 0
// range add: overflow sweep over all elements in use (skipped for a zero delta),
//   then a read and a write per element in the range, plus a checkpoint copy
//   when the new version lands on a multiple of the interval
// range sum: at the newest version a read and an add per element in the range; older
//   versions find the checkpoint by repeated subtraction of the interval, then sum
//   the range from it and replay each logged add after it (under one interval)
// the sweep and the replay both run through the one shared 72-bit adder
// writing checkpoint_interval starts a copy to checkpoint 0 during which busy is high
// reset empties the live array, all checkpoints and the history; array_size 64,
// checkpoint_interval 16
module versioned_range_add_sum_tree (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic [vras_pkg::IDX_W-1:0]    req_left_index,
   input  logic [vras_pkg::IDX_W-1:0]    req_right_index,
   input  logic [vras_pkg::DATA_W-1:0]   req_amount,
   input  logic [vras_pkg::VER_W-1:0]    req_query_version,
   output logic                          rsp_strobe,
   output logic [2:0]                    rsp_error_code,
   output logic [vras_pkg::VER_W-1:0]    rsp_new_version,
   output logic [vras_pkg::DATA_W-1:0]   rsp_range_total,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import vras_pkg::*;

   typedef enum logic [21:0] {
      S_IDLE   = 22'h000001,
      S_DECODE = 22'h000002,
      S_CK_RD  = 22'h000004,
      S_CK_E   = 22'h000008,
      S_CK_P   = 22'h000010,
      S_CK_MN  = 22'h000020,
      S_CK_MX  = 22'h000040,
      S_LD_WR  = 22'h000080,
      S_AD_LOG = 22'h000100,
      S_AD_RD  = 22'h000200,
      S_AD_WR  = 22'h000400,
      S_CP_RD  = 22'h000800,
      S_CP_WR  = 22'h001000,
      S_QL_RD  = 22'h002000,
      S_QL_ACC = 22'h004000,
      S_QD_DIV = 22'h008000,
      S_QS_RD  = 22'h010000,
      S_QS_ACC = 22'h020000,
      S_QR_RD  = 22'h040000,
      S_QR_MUL = 22'h080000,
      S_QR_ACC = 22'h100000,
      S_DONE   = 22'h200000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]         op_ff, op_in;
   logic [IDX_W-1:0]   l_ff, l_in, r_ff, r_in;
   logic [DATA_W-1:0]  amt_ff, amt_in;
   logic [VER_W-1:0]   qv_ff, qv_in;
   logic [SIZE_W-1:0]  k_ff, k_in;
   logic [WIDE_W-1:0]  p_ff, p_in, mn_ff, mn_in, mx_ff, mx_in, e_ff, e_in;
   logic               lt_mn_ff, lt_mn_in;
   logic [DATA_W-1:0]  acc_ff, acc_in, prod_ff, prod_in;
   logic [2:0]         err_ff, err_in;
   logic [VER_W-1:0]   outver_ff, outver_in;
   logic [VER_W-1:0]   version_ff, version_in, phase_ff, phase_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in, cslot_ff, cslot_in, q_ff, q_in;
   logic [VER_W-1:0]   rem_ff, rem_in, i_ff, i_in;
   logic               take_ff, take_in;
   logic               pend_ff, pend_in;
   logic               strobe_ff, strobe_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [IVL_W-1:0]   ivl_ff, ivl_in;
   logic [MAX_ELEMENTS-1:0]  lvld_ff, lvld_in;
   logic [MAX_SNAPSHOTS-1:0] svld_ff, svld_in;

   logic [DATA_W-1:0] live_mem [MAX_ELEMENTS];
   logic [DATA_W-1:0] snap_mem [SNAP_DEPTH];
   logic [2*IDX_W+DATA_W-1:0] log_mem [MAX_VERSIONS];

   logic                      live_we, snap_we, log_we;
   logic [IDX_W-1:0]          live_waddr;
   logic [DATA_W-1:0]         live_wdata;
   logic [DATA_W-1:0]         live_rd_ff, snap_rd_ff;
   logic                      live_rdv_ff, snap_rdv_ff;
   logic [2*IDX_W+DATA_W-1:0] log_rd_ff;
   logic [DATA_W-1:0]         live_val, snap_val;
   logic [SLOT_W+IDX_W-1:0]   snap_raddr, snap_waddr;

   logic [WIDE_W-1:0]  alu_a, alu_b, alu_res;
   logic               alu_sub;
   alu_flags_type      alu_flg;

   logic               cfg_we;
   logic [6:0]         wsize;
   logic [8:0]         wivl;
   logic               bad_range, in_rng, k_last;
   logic [IDX_W-1:0]   lg_first, lg_last, ol, orr;
   logic [DATA_W-1:0]  lg_delta;
   logic [SIZE_W-1:0]  cnt;
   logic [5:0]         next_slot;

   vras_alu u_alu (
      .op_a     (alu_a),
      .op_b     (alu_b),
      .subtract (alu_sub),
      .result   (alu_res),
      .flags    (alu_flg)
   );

   assign busy    = (state_ff != S_IDLE);
   assign pready  = 1'b1;
   assign cfg_we  = psel && penable && pwrite && pready;
   assign prdata  = (paddr[2] == REG_INTERVAL) ? {23'd0, ivl_ff} : {25'd0, size_ff};

   assign rsp_strobe      = strobe_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_new_version = outver_ff;
   assign rsp_range_total = acc_ff;

   assign live_val = live_rdv_ff ? live_rd_ff : '0;
   assign snap_val = snap_rdv_ff ? snap_rd_ff : '0;
   assign snap_raddr = {q_ff, k_ff[IDX_W-1:0]};
   assign snap_waddr = {cslot_ff, k_ff[IDX_W-1:0]};

   assign bad_range = (l_ff > r_ff) || ({1'b0, r_ff} >= size_ff);
   assign in_rng    = (k_ff[IDX_W-1:0] >= l_ff) && (k_ff[IDX_W-1:0] <= r_ff);
   assign k_last    = (k_ff == size_ff - SIZE_W'(1));
   assign next_slot = {1'b0, slot_ff} + 6'd1;

   assign lg_first = log_rd_ff[2*IDX_W+DATA_W-1:IDX_W+DATA_W];
   assign lg_last  = log_rd_ff[IDX_W+DATA_W-1:DATA_W];
   assign lg_delta = log_rd_ff[DATA_W-1:0];
   assign ol       = (lg_first > l_ff) ? lg_first : l_ff;
   assign orr      = (lg_last < r_ff) ? lg_last : r_ff;
   assign cnt      = (ol <= orr) ? ({1'b0, orr} - {1'b0, ol} + SIZE_W'(1)) : '0;

   assign wsize = (pwdata[6:0] < 7'd1) ? 7'd1 :
                  (pwdata[6:0] > 7'(MAX_ELEMENTS)) ? 7'(MAX_ELEMENTS) : pwdata[6:0];
   assign wivl  = (pwdata[8:0] < 9'(IVL_MIN)) ? 9'(IVL_MIN) :
                  (pwdata[8:0] > 9'(IVL_MAX)) ? 9'(IVL_MAX) : pwdata[8:0];

   // shared adder operand selection
   always_comb begin
      alu_a   = p_ff;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         S_CK_E: begin
            alu_a = sext_wide(live_val);
            if (op_ff == ACT_LOAD && k_ff[IDX_W-1:0] == l_ff) alu_a = sext_wide(amt_ff);
            if (op_ff == ACT_ADD && in_rng) alu_b = sext_wide(amt_ff);
         end
         S_CK_P:   alu_b = e_ff;
         S_CK_MN: begin
            alu_b   = mn_ff;
            alu_sub = 1'b1;
         end
         S_CK_MX: begin
            alu_b   = mx_ff;
            alu_sub = 1'b1;
         end
         S_AD_WR: begin
            alu_a = sext_wide(live_val);
            alu_b = sext_wide(amt_ff);
         end
         S_QL_ACC: begin
            alu_a = {8'd0, acc_ff};
            alu_b = {8'd0, live_val};
         end
         S_QS_ACC: begin
            alu_a = {8'd0, acc_ff};
            alu_b = {8'd0, snap_val};
         end
         S_QR_ACC: begin
            alu_a = {8'd0, acc_ff};
            alu_b = {8'd0, prod_ff};
         end
         S_QD_DIV: begin
            alu_a   = {{(WIDE_W-VER_W){1'b0}}, rem_ff};
            alu_b   = {{(WIDE_W-IVL_W){1'b0}}, ivl_ff};
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = p_ff;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      amt_in     = amt_ff;
      qv_in      = qv_ff;
      k_in       = k_ff;
      p_in       = p_ff;
      mn_in      = mn_ff;
      mx_in      = mx_ff;
      e_in       = e_ff;
      lt_mn_in   = lt_mn_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      err_in     = err_ff;
      outver_in  = outver_ff;
      version_in = version_ff;
      phase_in   = phase_ff;
      slot_in    = slot_ff;
      cslot_in   = cslot_ff;
      q_in       = q_ff;
      rem_in     = rem_ff;
      i_in       = i_ff;
      take_in    = take_ff;
      pend_in    = pend_ff;
      strobe_in  = 1'b0;
      size_in    = size_ff;
      ivl_in     = ivl_ff;
      lvld_in    = lvld_ff;
      svld_in    = svld_ff;
      live_we    = 1'b0;
      live_waddr = k_ff[IDX_W-1:0];
      live_wdata = alu_res[DATA_W-1:0];
      snap_we    = 1'b0;
      log_we     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cfg_we && paddr[2] == REG_SIZE) begin
               size_in    = wsize;
               lvld_in    = '0;
               svld_in[0] = 1'b0;
               version_in = '0;
               phase_in   = '0;
               slot_in    = '0;
            end else if (cfg_we && paddr[2] == REG_INTERVAL) begin
               ivl_in     = wivl;
               version_in = '0;
               phase_in   = '0;
               slot_in    = '0;
               cslot_in   = '0;
               k_in       = '0;
               pend_in    = 1'b0;
               state_in   = S_CP_RD;
            end else if (start) begin
               op_in    = req_action;
               l_in     = req_left_index;
               r_in     = req_right_index;
               amt_in   = req_amount;
               qv_in    = req_query_version;
               pend_in  = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            err_in    = ERR_OK;
            acc_in    = '0;
            outver_in = version_ff;
            k_in      = '0;
            p_in      = '0;
            mn_in     = '0;
            mx_in     = '0;
            take_in   = (phase_ff + VER_W'(1)) == VER_W'(ivl_ff);
            state_in  = S_DONE;
            case (op_ff)
               ACT_LOAD: begin
                  if ({1'b0, l_ff} >= size_ff) err_in = ERR_RANGE;
                  else state_in = S_CK_RD;
               end
               ACT_ADD: begin
                  if (bad_range) err_in = ERR_RANGE;
                  else if (version_ff >= VER_W'(MAX_VERSIONS)) err_in = ERR_FULL;
                  else if (take_in && next_slot >= 6'(MAX_SNAPSHOTS)) err_in = ERR_FULL;
                  else if (amt_ff == '0) state_in = S_AD_LOG;
                  else state_in = S_CK_RD;
               end
               ACT_SUM: begin
                  if (qv_ff > version_ff) err_in = ERR_VERSION;
                  else if (bad_range) err_in = ERR_RANGE;
                  else if (qv_ff == version_ff) begin
                     k_in     = {1'b0, l_ff};
                     state_in = S_QL_RD;
                  end else begin
                     rem_in   = qv_ff;
                     q_in     = '0;
                     state_in = S_QD_DIV;
                  end
               end
               default: err_in = ERR_RANGE;
            endcase
         end
         S_CK_RD: state_in = S_CK_E;
         S_CK_E: begin
            e_in     = alu_res;
            state_in = S_CK_P;
         end
         S_CK_P: begin
            p_in     = alu_res;
            state_in = S_CK_MN;
         end
         S_CK_MN: begin
            lt_mn_in = alu_flg.neg;
            if (!alu_flg.fits) begin
               err_in   = ERR_OVERFLOW;
               state_in = S_DONE;
            end else begin
               state_in = S_CK_MX;
            end
         end
         S_CK_MX: begin
            if (!alu_flg.fits) begin
               err_in   = ERR_OVERFLOW;
               state_in = S_DONE;
            end else begin
               if (lt_mn_ff) mn_in = p_ff;
               if (!alu_flg.neg && !alu_flg.zero) mx_in = p_ff;
               k_in = k_ff + SIZE_W'(1);
               if (!k_last) state_in = S_CK_RD;
               else if (op_ff == ACT_LOAD) state_in = S_LD_WR;
               else state_in = S_AD_LOG;
            end
         end
         S_LD_WR: begin
            live_we     = 1'b1;
            live_waddr  = l_ff;
            live_wdata  = amt_ff;
            lvld_in[l_ff] = 1'b1;
            version_in  = '0;
            phase_in    = '0;
            slot_in     = '0;
            cslot_in    = '0;
            outver_in   = '0;
            k_in        = '0;
            state_in    = S_CP_RD;
         end
         S_AD_LOG: begin
            log_we     = 1'b1;
            version_in = version_ff + VER_W'(1);
            outver_in  = version_ff + VER_W'(1);
            if (take_ff) begin
               phase_in = '0;
               slot_in  = next_slot[SLOT_W-1:0];
            end else begin
               phase_in = phase_ff + VER_W'(1);
            end
            cslot_in = next_slot[SLOT_W-1:0];
            k_in     = {1'b0, l_ff};
            state_in = S_AD_RD;
         end
         S_AD_RD: state_in = S_AD_WR;
         S_AD_WR: begin
            live_we = 1'b1;
            lvld_in[k_ff[IDX_W-1:0]] = 1'b1;
            if (k_ff[IDX_W-1:0] == r_ff) begin
               k_in     = '0;
               state_in = take_ff ? S_CP_RD : S_DONE;
            end else begin
               k_in     = k_ff + SIZE_W'(1);
               state_in = S_AD_RD;
            end
         end
         S_CP_RD: state_in = S_CP_WR;
         S_CP_WR: begin
            snap_we           = 1'b1;
            svld_in[cslot_ff] = 1'b1;
            if (k_ff[IDX_W-1:0] == IDX_W'(MAX_ELEMENTS - 1)) begin
               state_in = S_DONE;
            end else begin
               k_in     = k_ff + SIZE_W'(1);
               state_in = S_CP_RD;
            end
         end
         S_QL_RD: state_in = S_QL_ACC;
         S_QL_ACC: begin
            acc_in = alu_res[DATA_W-1:0];
            k_in   = k_ff + SIZE_W'(1);
            if (k_ff[IDX_W-1:0] == r_ff) state_in = S_DONE;
            else state_in = S_QL_RD;
         end
         S_QD_DIV: begin
            if (!alu_flg.neg) begin
               rem_in = alu_res[VER_W-1:0];
               q_in   = q_ff + SLOT_W'(1);
            end else begin
               i_in     = qv_ff - rem_ff;
               k_in     = {1'b0, l_ff};
               state_in = S_QS_RD;
            end
         end
         S_QS_RD: state_in = S_QS_ACC;
         S_QS_ACC: begin
            acc_in = alu_res[DATA_W-1:0];
            k_in   = k_ff + SIZE_W'(1);
            if (k_ff[IDX_W-1:0] == r_ff) state_in = S_QR_RD;
            else state_in = S_QS_RD;
         end
         S_QR_RD: begin
            if (i_ff == qv_ff) state_in = S_DONE;
            else state_in = S_QR_MUL;
         end
         S_QR_MUL: begin
            prod_in  = DATA_W'(lg_delta * cnt);
            state_in = S_QR_ACC;
         end
         S_QR_ACC: begin
            acc_in   = alu_res[DATA_W-1:0];
            i_in     = i_ff + VER_W'(1);
            state_in = S_QR_RD;
         end
         S_DONE: begin
            strobe_in = pend_ff;
            pend_in   = 1'b0;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         version_ff <= '0;
         phase_ff   <= '0;
         slot_ff    <= '0;
         pend_ff    <= 1'b0;
         strobe_ff  <= 1'b0;
         size_ff    <= SIZE_W'(MAX_ELEMENTS);
         ivl_ff     <= IVL_W'(IVL_MIN);
         lvld_ff    <= '0;
         svld_ff    <= '0;
         err_ff     <= ERR_OK;
         outver_ff  <= '0;
         acc_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         version_ff <= version_in;
         phase_ff   <= phase_in;
         slot_ff    <= slot_in;
         pend_ff    <= pend_in;
         strobe_ff  <= strobe_in;
         size_ff    <= size_in;
         ivl_ff     <= ivl_in;
         lvld_ff    <= lvld_in;
         svld_ff    <= svld_in;
         err_ff     <= err_in;
         outver_ff  <= outver_in;
         acc_ff     <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      amt_ff   <= amt_in;
      qv_ff    <= qv_in;
      k_ff     <= k_in;
      p_ff     <= p_in;
      mn_ff    <= mn_in;
      mx_ff    <= mx_in;
      e_ff     <= e_in;
      lt_mn_ff <= lt_mn_in;
      prod_ff  <= prod_in;
      cslot_ff <= cslot_in;
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      i_ff     <= i_in;
      take_ff  <= take_in;
   end

   // live array
   always_ff @(posedge clock) begin
      if (live_we) live_mem[live_waddr] <= live_wdata;
      live_rd_ff  <= live_mem[k_ff[IDX_W-1:0]];
      live_rdv_ff <= lvld_ff[k_ff[IDX_W-1:0]];
   end

   // checkpoint copies
   always_ff @(posedge clock) begin
      if (snap_we) snap_mem[snap_waddr] <= live_val;
      snap_rd_ff  <= snap_mem[snap_raddr];
      snap_rdv_ff <= svld_ff[q_ff];
   end

   // history of range adds
   always_ff @(posedge clock) begin
      if (log_we) log_mem[version_ff[LOG_W-1:0]] <= {l_ff, r_ff, amt_ff};
      log_rd_ff <= log_mem[i_ff[LOG_W-1:0]];
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item transfer not followed by busy");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");
   a_error_no_total: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_error_code != ERR_OK |-> rsp_range_total == '0)
      else $error("failed item returned a nonzero total");
   a_version_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_new_version <= VER_W'(MAX_VERSIONS))
      else $error("version beyond history depth");
`endif
endmodule

### dv/tb_versioned_range_add_sum_tree.sv
// testbench for the versioned range add and range sum block
`timescale 1ns / 100ps

module tb_versioned_range_add_sum_tree;
   import vras_pkg::*;

   typedef logic signed [DATA_W-1:0] elem_arr_t [MAX_ELEMENTS];
   typedef struct {
      logic [2:0]        err;
      logic [VER_W-1:0]  ver;
      logic [DATA_W-1:0] total;
   } tree_result_t;

   localparam logic [1:0] ACT_UNUSED    = 2'd3;
   localparam logic [2:0] ADDR_SIZE     = 3'd0;
   localparam logic [2:0] ADDR_INTERVAL = 3'd4;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_action = '0;
   logic [IDX_W-1:0] req_left_index = '0;
   logic [IDX_W-1:0] req_right_index = '0;
   logic [DATA_W-1:0] req_amount = '0;
   logic [VER_W-1:0] req_query_version = '0;
   logic rsp_strobe;
   logic [2:0] rsp_error_code;
   logic [VER_W-1:0] rsp_new_version;
   logic [DATA_W-1:0] rsp_range_total;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   versioned_range_add_sum_tree i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   elem_arr_t live_elems;
   elem_arr_t version_elems [0:MAX_VERSIONS];
   int version_total;
   int elems_in_use;
   int ckpt_interval;

   tree_result_t pending_results [$];
   int mismatches = 0;
   int err_seen [8];
   int stall_count = 0;

   // every range sum of a with d added over l..r stays inside int64
   function automatic bit all_sums_fit(elem_arr_t a, int n, int l, int r,
                                       logic [DATA_W-1:0] d);
      logic signed [WIDE_W-1:0] p, mn, mx, e, d1, d2;
      p = '0; mn = '0; mx = '0;
      for (int k = 0; k < n; k++) begin
         e = sext_wide(a[k]);
         if (k >= l && k <= r) e = e + sext_wide(d);
         p = p + e;
         d1 = p - mn;
         d2 = p - mx;
         if (!(d1[WIDE_W-1:DATA_W-1] == '0 || d1[WIDE_W-1:DATA_W-1] == '1)) return 0;
         if (!(d2[WIDE_W-1:DATA_W-1] == '0 || d2[WIDE_W-1:DATA_W-1] == '1)) return 0;
         if (p < mn) mn = p;
         if (p > mx) mx = p;
      end
      return 1;
   endfunction

   function automatic tree_result_t predict_tree_op(logic [1:0] act, int l, int r,
                                                    logic [DATA_W-1:0] amt, int qv);
      tree_result_t res;
      elem_arr_t nxt;
      res.err = ERR_OK;
      res.ver = VER_W'(version_total);
      res.total = '0;
      nxt = live_elems;
      case (act)
         ACT_LOAD: begin
            if (l >= elems_in_use) res.err = ERR_RANGE;
            else begin
               nxt[l] = amt;
               if (!all_sums_fit(nxt, elems_in_use, 1, 0, '0)) res.err = ERR_OVERFLOW;
               else begin
                  live_elems = nxt;
                  version_total = 0;
                  version_elems[0] = nxt;
                  res.ver = '0;
               end
            end
         end
         ACT_ADD: begin
            if (l > r || r >= elems_in_use) res.err = ERR_RANGE;
            else if (version_total >= MAX_VERSIONS) res.err = ERR_FULL;
            else if (amt != 0 && !all_sums_fit(live_elems, elems_in_use, l, r, amt))
               res.err = ERR_OVERFLOW;
            else begin
               for (int k = l; k <= r; k++) nxt[k] = nxt[k] + amt;
               live_elems = nxt;
               version_total++;
               version_elems[version_total] = nxt;
               res.ver = VER_W'(version_total);
            end
         end
         ACT_SUM: begin
            if (qv > version_total) res.err = ERR_VERSION;
            else if (l > r || r >= elems_in_use) res.err = ERR_RANGE;
            else for (int k = l; k <= r; k++) res.total = res.total + version_elems[qv][k];
         end
         default: res.err = ERR_RANGE;
      endcase
      return res;
   endfunction

   task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      tree_result_t want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("mismatch at %0t: result with no transfer outstanding", $realtime);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            err_seen[want.err]++;
            if (rsp_error_code !== want.err)
               report("error_code", DATA_W'(rsp_error_code), DATA_W'(want.err));
            if (rsp_new_version !== want.ver)
               report("new_version", DATA_W'(rsp_new_version), DATA_W'(want.ver));
            if (rsp_range_total !== want.total)
               report("range_total", rsp_range_total, want.total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count == STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // caller sits at a falling edge; returns at a falling edge with start still high
   task automatic send_item(logic [1:0] act, int l, int r, logic [DATA_W-1:0] amt, int qv);
      logic accepted;
      tree_result_t expected;
      req_action <= act;
      req_left_index <= IDX_W'(l);
      req_right_index <= IDX_W'(r);
      req_amount <= amt;
      req_query_version <= VER_W'(qv);
      start <= 1'b1;
      accepted = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = !busy;
      end
      expected = predict_tree_op(act, l, r, amt, qv);
      pending_results = {pending_results, expected};
      @(negedge clock);
   endtask

   task automatic pause_sender(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) pause_sender(0);
      else if (pick < 92) pause_sender($urandom_range(1, 4));
      else pause_sender($urandom_range(20, 200));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      int v;
      drain();
      psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_SIZE) begin
         v = value & 127;
         elems_in_use = v < 1 ? 1 : (v > MAX_ELEMENTS ? MAX_ELEMENTS : v);
         foreach (live_elems[k]) live_elems[k] = '0;
      end else begin
         v = value & 511;
         ckpt_interval = v < IVL_MIN ? IVL_MIN : (v > IVL_MAX ? IVL_MAX : v);
      end
      version_elems[0] = live_elems;
      version_total = 0;
      @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] random_amount();
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom};
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return 64'h8000_0000_0000_0000;
         3: return '0;
         4: return 64'(signed'($urandom_range(0, 1 << 20)) - (1 << 19)) <<< $urandom_range(0, 40);
         default: return 64'(signed'($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   task automatic test_directed();
      csr_write(ADDR_SIZE, 64);
      csr_write(ADDR_INTERVAL, 16);
      send_item(ACT_LOAD, 0, 0, 64'h7fff_ffff_ffff_ffff, 0);
      send_item(ACT_LOAD, 63, 0, 64'h8000_0000_0000_0000, 0);
      send_item(ACT_LOAD, 1, 0, 64'd1, 0);
      send_item(ACT_LOAD, 63, 0, 64'h8000_0000_0000_0001, 0);
      send_item(ACT_SUM, 0, 63, '0, 0);
      send_item(ACT_ADD, 0, 0, 64'd1, 0);
      send_item(ACT_ADD, 5, 63, '0, 0);
      send_item(ACT_ADD, 7, 6, 64'd3, 0);
      send_item(ACT_ADD, 10, 20, 64'hffff_ffff_ffff_fffb, 0);
      send_item(ACT_SUM, 0, 63, '0, 2);
      send_item(ACT_SUM, 0, 0, '0, 0);
      send_item(ACT_SUM, 9, 8, '0, 1);
      send_item(ACT_SUM, 0, 0, '0, 3);
      send_item(ACT_SUM, 0, 0, '0, 511);
      send_item(ACT_UNUSED, 63, 63, '1, 511);
      csr_write(ADDR_SIZE, 3);
      send_item(ACT_LOAD, 3, 0, 64'd5, 0);
      send_item(ACT_ADD, 0, 3, 64'd5, 0);
      send_item(ACT_LOAD, 2, 0, 64'd9, 0);
      send_item(ACT_SUM, 0, 2, '0, 0);
      pause_sender(0);
      drain();
   endtask

   task automatic test_history_full();
      csr_write(ADDR_SIZE, 0);
      csr_write(ADDR_INTERVAL, 0);
      send_item(ACT_LOAD, 0, 0, 64'd7, 0);
      for (int i = 0; i < MAX_VERSIONS; i++) begin
         send_item(ACT_ADD, 0, 0, (i % 3 == 0) ? 64'd0 : 64'd1, 0);
         if ($urandom_range(0, 3) == 0) random_gap();
      end
      send_item(ACT_ADD, 0, 0, 64'd1, 0);
      send_item(ACT_SUM, 0, 0, '0, 256);
      send_item(ACT_SUM, 0, 0, '0, 255);
      send_item(ACT_SUM, 0, 0, '0, 100);
      send_item(ACT_SUM, 0, 0, '0, 257);
      drain();
   endtask

   task automatic test_random(int size_val, int ivl_val, int count);
      int pick, l, r;
      csr_write(ADDR_SIZE, size_val);
      csr_write(ADDR_INTERVAL, ivl_val);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         l = $urandom_range(0, elems_in_use - 1);
         r = $urandom_range(l, elems_in_use - 1);
         if (pick < 6)
            send_item(ACT_LOAD, $urandom_range(0, 4) == 0 ? $urandom_range(0, 63) : l, 0,
                      random_amount(), $urandom_range(0, 511));
         else if (pick < 45)
            send_item(ACT_ADD, l, r, random_amount(), $urandom_range(0, 511));
         else if (pick < 90)
            send_item(ACT_SUM, l, r, random_amount(), $urandom_range(0, version_total));
         else
            send_item(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                      {$urandom, $urandom}, $urandom_range(0, 511));
         if ($urandom_range(0, 149) == 0) drain();
         else random_gap();
      end
      drain();
   endtask

   initial begin
      foreach (err_seen[k]) err_seen[k] = 0;
      elems_in_use = MAX_ELEMENTS;
      ckpt_interval = IVL_MIN;
      version_total = 0;
      foreach (live_elems[k]) live_elems[k] = '0;
      version_elems[0] = live_elems;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_history_full();
      test_random(64, 16, 330);
      test_random(7, 511, 280);
      test_random(127, 37, 280);
      test_random(2, 300, 180);
      test_random(33, 17, 200);
      start <= 1'b0;
      repeat (200) @(posedge clock);
      $display("covered loads, range adds, range sums at old and newest versions,");
      $display("results ok %0d, range %0d, version %0d, overflow %0d, full %0d",
               err_seen[ERR_OK], err_seen[ERR_RANGE], err_seen[ERR_VERSION],
               err_seen[ERR_OVERFLOW], err_seen[ERR_FULL]);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches,
                  pending_results.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
rtl/vras_pkg.sv
rtl/vras_alu.sv
rtl/versioned_range_add_sum_tree.sv
dv/tb_versioned_range_add_sum_tree.sv
